// ===== hw/rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
package lcs_pkg;

  localparam int LCS_WIDTH = 31;
  localparam int STATUS_W  = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_SOLVED  = 2'd0;
  localparam status_t ST_NO_SOL  = 2'd1;
  localparam status_t ST_ZERO_N  = 2'd2;

endpackage

// ===== hw/rtl/lcs_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module lcs_div #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WIDTH-1:0] num,
  input  logic [WIDTH-1:0] den,
  output logic             done,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] rem
);
  localparam int CW = $clog2(WIDTH);

  logic [CW-1:0]  cnt;
  logic           run;
  logic [WIDTH-1:0] shr;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0] trial;
  logic           fits;

  assign trial = {rem, shr[WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quo   = shr;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(WIDTH - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shr <= num;
      dvs <= den;
      rem <= '0;
    end else if (run) begin
      // shift quotient bits into the dividend register as it empties
      shr <= {shr[WIDTH-2:0], fits};
      rem <= fits ? WIDTH'(trial - {1'b0, dvs}) : trial[WIDTH-1:0];
    end
  end
endmodule

// ===== hw/rtl/lcs_mulmod.sv =====
`timescale 1ns / 1ps
// Shift-and-add modular product, one multiplier bit per cycle.
// Operands must be below the modulus.
module lcs_mulmod #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WIDTH-1:0] opx,
  input  logic [WIDTH-1:0] opy,
  input  logic [WIDTH-1:0] modv,
  output logic             done,
  output logic [WIDTH-1:0] prod
);
  localparam int CW = $clog2(WIDTH);

  logic [CW-1:0]    cnt;
  logic             run;
  logic [WIDTH-1:0] xx;
  logic [WIDTH-1:0] yy;
  logic [WIDTH-1:0] mm;
  logic [WIDTH:0]   sa;
  logic [WIDTH:0]   sx;

  assign sa = {1'b0, prod} + {1'b0, xx};
  assign sx = {1'b0, xx} + {1'b0, xx};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(WIDTH - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod <= '0;
      xx   <= opx;
      yy   <= opy;
      mm   <= modv;
    end else if (run) begin
      if (yy[0]) begin
        prod <= (sa >= {1'b0, mm}) ? WIDTH'(sa - {1'b0, mm}) : sa[WIDTH-1:0];
      end
      xx <= (sx >= {1'b0, mm}) ? WIDTH'(sx - {1'b0, mm}) : sx[WIDTH-1:0];
      yy <= yy >> 1;
    end
  end
endmodule

// ===== hw/rtl/linear_congruence_solver.sv =====
`timescale 1ns / 1ps
// Solves a*x = b (mod n). A request is taken when start is high and busy is
// low; busy then stays high until the one-cycle done strobe, which the
// receiver must capture as it cannot stall the block. All divisions and
// products run on one bit-serial divider and one bit-serial modular
// multiplier. A request runs one division for each gcd round, then up to
// five more divisions, a division and a product for each inverse round and
// a final product, so its length is set by the number of Euclid rounds. A
// zero modulus answers on the cycle after the request.
module linear_congruence_solver #(
  parameter int WIDTH = lcs_pkg::LCS_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [WIDTH-1:0]      coeff_a,
  input  logic [WIDTH-1:0]      rhs_b,
  input  logic [WIDTH-1:0]      modulus_n,
  output logic                  done,
  output logic [WIDTH-1:0]      solution_x,
  output logic [WIDTH-1:0]      reduced_modulus,
  output logic [WIDTH-1:0]      common_divisor,
  output lcs_pkg::status_t      status
);
  import lcs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0,  S_GCD = 4'd1,  S_GCDW = 4'd2,
                         S_M    = 4'd3,  S_BD  = 4'd4,  S_AD   = 4'd5,
                         S_AM   = 4'd6,  S_BM  = 4'd7,  S_INV  = 4'd8,
                         S_IDIV = 4'd9,  S_IMUL = 4'd10, S_XM  = 4'd11,
                         S_FIN  = 4'd12;

  logic [3:0] state;
  logic [WIDTH-1:0] ra, rb, rn, gx, gy, bq, ar, br, r0, r1, s0, s1;
  logic [WIDTH-1:0] ns;

  logic             div_go, div_done;
  logic [WIDTH-1:0] div_num, div_den, div_q, div_r;
  logic             mul_go, mul_done;
  logic [WIDTH-1:0] mul_x, mul_y, mul_p;

  lcs_div #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q), .rem(div_r)
  );

  lcs_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .opx(mul_x), .opy(mul_y),
    .modv(reduced_modulus), .done(mul_done), .prod(mul_p)
  );

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIN);
  // s0 - q*s1 mod m
  assign ns = (s0 >= mul_p) ? s0 - mul_p : s0 + (reduced_modulus - mul_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      div_go <= 1'b0;
      mul_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      mul_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ra <= coeff_a;
            rb <= rhs_b;
            rn <= modulus_n;
            gx <= coeff_a;
            gy <= modulus_n;
            if (modulus_n == '0) begin
              solution_x      <= '0;
              reduced_modulus <= '0;
              common_divisor  <= '0;
              status          <= ST_ZERO_N;
              state           <= S_FIN;
            end else begin
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          div_go <= 1'b1;
          if (gy == '0) begin
            common_divisor <= gx;
            div_num        <= rn;
            div_den        <= gx;
            state          <= S_M;
          end else begin
            div_num <= gx;
            div_den <= gy;
            state   <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (div_done) begin
            gx    <= gy;
            gy    <= div_r;
            state <= S_GCD;
          end
        end
        S_M: begin
          if (div_done) begin
            reduced_modulus <= div_q;
            div_num <= rb;
            div_den <= common_divisor;
            div_go  <= 1'b1;
            state   <= S_BD;
          end
        end
        S_BD: begin
          if (div_done) begin
            bq <= div_q;
            if (div_r != '0) begin
              solution_x <= '0;
              status     <= ST_NO_SOL;
              state      <= S_FIN;
            end else begin
              div_num <= ra;
              div_den <= common_divisor;
              div_go  <= 1'b1;
              state   <= S_AD;
            end
          end
        end
        S_AD: begin
          if (div_done) begin
            div_num <= div_q;
            div_den <= reduced_modulus;
            div_go  <= 1'b1;
            state   <= S_AM;
          end
        end
        S_AM: begin
          if (div_done) begin
            ar      <= div_r;
            div_num <= bq;
            div_den <= reduced_modulus;
            div_go  <= 1'b1;
            state   <= S_BM;
          end
        end
        S_BM: begin
          if (div_done) begin
            br <= div_r;
            if (reduced_modulus == WIDTH'(1)) begin
              // inverse is zero, so is the solution
              solution_x <= '0;
              status     <= ST_SOLVED;
              state      <= S_FIN;
            end else begin
              r0    <= ar;
              r1    <= reduced_modulus;
              s0    <= WIDTH'(1);
              s1    <= '0;
              state <= S_INV;
            end
          end
        end
        S_INV: begin
          if (r1 == '0) begin
            mul_x  <= s0;
            mul_y  <= br;
            mul_go <= 1'b1;
            state  <= S_XM;
          end else begin
            div_num <= r0;
            div_den <= r1;
            div_go  <= 1'b1;
            state   <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_done) begin
            r0     <= r1;
            r1     <= div_r;
            mul_x  <= div_q;
            mul_y  <= s1;
            mul_go <= 1'b1;
            state  <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (mul_done) begin
            s0    <= s1;
            s1    <= ns;
            state <= S_INV;
          end
        end
        S_XM: begin
          if (mul_done) begin
            solution_x <= mul_p;
            status     <= ST_SOLVED;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/lcs_checker.sv =====
`timescale 1ns / 1ps
module lcs_checker #(
  parameter int WIDTH = lcs_pkg::LCS_WIDTH
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [WIDTH-1:0] solution_x,
  input logic [WIDTH-1:0] reduced_modulus,
  input logic [WIDTH-1:0] common_divisor,
  input lcs_pkg::status_t status
);
  import lcs_pkg::*;

  // accepted request keeps the block busy
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not held");

  // strobe only while working, and never two in a row
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("strobe while idle");
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy) else $error("repeated result");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_ZERO_N |-> solution_x == '0 && reduced_modulus == '0
      && common_divisor == '0) else $error("zero modulus result");

  a_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_SOLVED || status == ST_NO_SOL || status == ST_ZERO_N)
    else $error("bad status");
endmodule

bind linear_congruence_solver lcs_checker #(.WIDTH(WIDTH)) u_lcs_checker (.*);

// ===== test/tb_linear_congruence_solver.sv =====
`timescale 1ns / 1ps
module tb_linear_congruence_solver;
  import lcs_pkg::*;

  localparam int W = LCS_WIDTH;
  localparam logic [W-1:0] MAXV = {W{1'b1}};

  typedef struct {
    logic [W-1:0] x;
    logic [W-1:0] m;
    logic [W-1:0] d;
    status_t      st;
  } solution_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [W-1:0] coeff_a = '0;
  logic [W-1:0] rhs_b = '0;
  logic [W-1:0] modulus_n = '0;
  logic done;
  logic [W-1:0] solution_x;
  logic [W-1:0] reduced_modulus;
  logic [W-1:0] common_divisor;
  status_t status;

  solution_t pending_solutions[$];
  int error_count = 0;
  int request_count = 0;
  int checked_count = 0;
  int solved_count = 0;
  int nosol_count = 0;
  int zero_n_count = 0;

  linear_congruence_solver DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coeff_a(coeff_a), .rhs_b(rhs_b), .modulus_n(modulus_n),
    .done(done), .solution_x(solution_x), .reduced_modulus(reduced_modulus),
    .common_divisor(common_divisor), .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Signed extended Euclid; values stay well inside 64 bits at 31-bit widths.
  function automatic longint unsigned modular_inverse(longint unsigned v,
                                                      longint unsigned m);
    longint r0, r1, s0, s1, q, t;
    if (m <= 1) return 0;
    r0 = longint'(v % m);
    r1 = longint'(m);
    s0 = 1;
    s1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1; r0 = r1; r1 = t;
      t = s0 - q * s1; s0 = s1; s1 = t;
    end
    s0 = s0 % longint'(m);
    if (s0 < 0) s0 = s0 + longint'(m);
    return longint'(s0);
  endfunction

  function automatic solution_t solve_congruence(logic [W-1:0] a, logic [W-1:0] b,
                                                 logic [W-1:0] n);
    solution_t s;
    longint unsigned d, m, ar, br, inv;
    s.x = '0; s.m = '0; s.d = '0; s.st = ST_ZERO_N;
    if (n == 0) return s;
    d = gcd_of(a, n);
    m = n / d;
    s.m = m[W-1:0];
    s.d = d[W-1:0];
    if (b % d != 0) begin
      s.st = ST_NO_SOL;
      return s;
    end
    ar = (a / d) % m;
    br = (b / d) % m;
    inv = modular_inverse(ar, m);
    // both factors < 2^31, product fits in 64 bits
    s.x = W'((inv * br) % m);
    s.st = ST_SOLVED;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // start stays high after the accepting edge until the next request or a drain
  task automatic send_request(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] n,
                              bit idle = 1'b1);
    int gap;
    gap = idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coeff_a <= a;
    rhs_b <= b;
    modulus_n <= n;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_solutions.push_back(solve_congruence(a, b, n));
    request_count++;
  endtask

  always @(posedge clk) begin
    solution_t e;
    if (!rst && done) begin
      if (pending_solutions.size() == 0) begin
        $display("unexpected result x=%0d", solution_x);
        error_count++;
      end else begin
        e = pending_solutions.pop_front();
        checked_count++;
        if (solution_x !== e.x) report_mismatch("solution_x", solution_x, e.x);
        if (reduced_modulus !== e.m)
          report_mismatch("reduced_modulus", reduced_modulus, e.m);
        if (common_divisor !== e.d)
          report_mismatch("common_divisor", common_divisor, e.d);
        if (status !== e.st) report_mismatch("status", W'(status), W'(e.st));
        case (e.st)
          ST_SOLVED: solved_count++;
          ST_NO_SOL: nosol_count++;
          default:   zero_n_count++;
        endcase
      end
    end
  end

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(0, 0, 0);
    send_request(MAXV, MAXV, 0);
    send_request(3, 4, 7);
    send_request(0, 0, 5);
    send_request(0, 10, 5);
    send_request(0, 3, 5);
    send_request(4, 2, 6);
    send_request(4, 3, 6);
    send_request(5, 7, 1);
    send_request(MAXV, MAXV, MAXV);
    send_request(MAXV, 1, MAXV - 1);
    send_request(1, MAXV, MAXV);
    send_request(MAXV - 1, 12345, 2147483629);
    send_request(1836311903, 1, 1134903170);
    send_request(1134903170, MAXV, 1836311903);
    send_request(12, 18, 30);
    send_request(10, MAXV, 1);
    send_request(MAXV, 0, 3);
    send_request(1 << (W - 1), 1 << (W - 1), 1 << (W - 2));
    send_request(6, 9, 15, 1'b0);
    send_request(7, 5, 13, 1'b0);
  endtask

  task automatic test_random();
    logic [W-1:0] a, b, n, d, k;
    int sel;
    for (int i = 0; i < 300; i++) begin
      sel = $urandom_range(0, 9);
      n = W'($urandom);
      a = W'($urandom);
      b = W'($urandom);
      if (sel < 3) begin
        // force a shared factor and a right-hand side that it divides
        d = W'($urandom_range(2, 1000));
        k = W'($urandom_range(1, 2000000));
        n = d * k;
        a = d * W'($urandom_range(0, 2000000));
        b = d * W'($urandom_range(0, 2000000));
      end else if (sel == 3) begin
        n = W'($urandom_range(1, 40));
        a = W'($urandom_range(0, 80));
        b = W'($urandom_range(0, 80));
      end else if (sel == 4 && i % 20 == 0) begin
        n = '0;
      end
      send_request(a, b, n, i % 50 < 40);
      if (i == 150) wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d requests: %0d solved, %0d without solution, %0d zero modulus",
             request_count, solved_count, nosol_count, zero_n_count);
    if (error_count == 0 && checked_count == request_count) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule
